/* src/thp_sensor_compensation_macros.svh */
// Assertion macros for the sensor compensation block
`ifndef THP_SENSOR_COMPENSATION_MACROS_SVH
`define THP_SENSOR_COMPENSATION_MACROS_SVH
`ifndef NO_ASSERTIONS
`define THP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define THP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define THP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define THP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/thp_pkg.sv */
// Types, constants and arithmetic helpers of the sensor compensation block
`default_nettype none
package thp_pkg;
	localparam logic [2:0] CFG_TEMP      = 3'd0;
	localparam logic [2:0] CFG_PRESS_LO  = 3'd1;
	localparam logic [2:0] CFG_PRESS_HI  = 3'd2;
	localparam logic [2:0] CFG_PRESS_P9  = 3'd3;
	localparam logic [2:0] CFG_HUM       = 3'd4;

	localparam logic [31:0] K_64000      = 32'd64000;
	localparam logic [31:0] K_1048576    = 32'd1048576;
	localparam logic [31:0] K_3125       = 32'd3125;
	localparam logic [31:0] K_76800      = 32'd76800;
	localparam logic [31:0] K_16384      = 32'd16384;
	localparam logic [31:0] K_2097152    = 32'd2097152;
	localparam logic [31:0] K_8192       = 32'd8192;
	localparam logic [31:0] K_32768      = 32'd32768;
	localparam logic [31:0] K_128        = 32'd128;
	localparam logic [31:0] K_HUM_MAX    = 32'd419430400;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
		logic [15:0] raw_humidity;
	} raw_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_pa;
		logic [16:0]        humidity_q10;
	} result_t;

	typedef struct packed {
		logic [31:0] fine;
		logic [19:0] raw_pressure;
		logic [15:0] raw_humidity;
	} fine_beat_t;

	typedef struct packed {
		logic [31:0] t1, t2, t3;
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] h1, h2, h3, h4, h5, h6;
	} coeff_t;

	function automatic logic [31:0] sra(input logic [31:0] x, input int n);
		sra = $unsigned($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		mul32 = a * b;
	endfunction
endpackage
`default_nettype wire

/* src/thp_if.sv */
// Valid/ready channel interfaces for raw readings and compensated results
`default_nettype none
interface thp_in_if;
	logic          valid;
	logic          ready;
	thp_pkg::raw_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface thp_out_if;
	logic             valid;
	logic             ready;
	thp_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/thp_front.sv */
// Front pipeline: accept raw readings and compute the fine temperature
`default_nettype none
module thp_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	thp_in_if.sink               in_ch,
	input  wire thp_pkg::coeff_t coeff,
	output logic                 push_valid,
	output thp_pkg::fine_beat_t  push_beat,
	input  wire logic            push_ready
);
	logic [3:0]  vld_q;
	logic        en;
	logic [31:0] x_s1, d_s1, m1_s2, dd_s2, a_s3, m2_s3, fine_s4;
	logic [19:0] p_s1, p_s2, p_s3, p_s4;
	logic [15:0] h_s1, h_s2, h_s3, h_s4;

	assign en = !vld_q[3] || push_ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[2:0], in_ch.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= 32'(in_ch.data.raw_temperature >> 3) - (coeff.t1 << 1);
			d_s1 <= 32'(in_ch.data.raw_temperature >> 4) - coeff.t1;
			p_s1 <= in_ch.data.raw_pressure;
			h_s1 <= in_ch.data.raw_humidity;
			m1_s2 <= thp_pkg::mul32(x_s1, coeff.t2);
			dd_s2 <= thp_pkg::mul32(d_s1, d_s1);
			p_s2 <= p_s1;
			h_s2 <= h_s1;
			a_s3 <= thp_pkg::sra(m1_s2, 11);
			m2_s3 <= thp_pkg::mul32(thp_pkg::sra(dd_s2, 12), coeff.t3);
			p_s3 <= p_s2;
			h_s3 <= h_s2;
			fine_s4 <= a_s3 + thp_pkg::sra(m2_s3, 14);
			p_s4 <= p_s3;
			h_s4 <= h_s3;
		end
	end

	assign push_valid = vld_q[3];
	assign push_beat.fine = fine_s4;
	assign push_beat.raw_pressure = p_s4;
	assign push_beat.raw_humidity = h_s4;
endmodule
`default_nettype wire

/* src/thp_queue.sv */
// Short queue between the front and back pipelines
`default_nettype none
`include "thp_sensor_compensation_macros.svh"
module thp_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	input  wire thp_pkg::fine_beat_t push_beat,
	output logic                     push_ready,
	output logic                     pop_valid,
	output thp_pkg::fine_beat_t      pop_beat,
	input  wire logic                pop_ready
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	thp_pkg::fine_beat_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign push_ready = count_q != FULL;
	assign pop_valid  = count_q != '0;
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;
	assign pop_beat = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_beat;
		end
	end

	`THP_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL)
	`THP_ASSERT_NXT(a_fill_step, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)
	`THP_ASSERT_IMP(a_empty_ptrs, clk, arst_n, count_q == '0, wr_ptr_q == rd_ptr_q)
endmodule
`default_nettype wire

/* src/thp_back.sv */
// Back pipeline: temperature output, pressure with pipelined divider, humidity
`default_nettype none
module thp_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire thp_pkg::fine_beat_t in_beat,
	output logic                     in_ready,
	input  wire thp_pkg::coeff_t     coeff,
	thp_out_if.source                out_ch
);
	localparam int DIVN = 32;
	localparam int NST  = 10 + DIVN + 4;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] num;
		logic [31:0] den;
		logic        hi;
		logic        zero;
		logic [31:0] temp;
		logic [16:0] hum;
	} div_t;

	logic [NST-1:0] vld_q;
	logic           en;

	logic [31:0] temp_s1, pa_s1, q_s1, hd_s1;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4;
	logic [15:0] adch_s1, adch_s2;
	logic [31:0] temp_s2, qq_s2, mp5_s2, mp2_s2, h5d_s2, h6d_s2, h3d_s2;
	logic [31:0] temp_s3, b1_s3, c_s3, mp5_s3, mp2_s3, ha_s3, hb_s3, hc_s3;
	logic [31:0] temp_s4, b_s4, a1_s4, ha_s4, hbc_s4;
	logic [31:0] temp_s5, dv_s5, pn_s5, hb2_s5, ha_s5;
	logic [31:0] temp_s6, diva_s6, pm_s6, hb3_s6, ha_s6;
	logic [31:0] temp_s7, diva_s7, num_s7, ha_s7, hb4_s7;
	logic        hi_s7;
	logic [31:0] temp_s8, diva_s8, num_s8, hum_s8;
	logic [31:0] temp_s9, diva_s9, num_s9, hum_s9, hq_s9;
	logic [31:0] temp_s10, diva_s10, num_s10, hum_s10, hs_s10;
	logic        hi_s8, hi_s9, hi_s10, zero_s8, zero_s9, zero_s10;
	logic [31:0] hfin;
	div_t        div_in;
	div_t        div_q [DIVN];
	logic [31:0] temp_s12, pres_s12, temp_s13, pres_s13, ss_s13, pb_s13;
	logic [31:0] temp_s14, pres_s14, pa2_s14, pb_s14;
	logic [16:0] hum_s12, hum_s13, hum_s14;
	logic        zero_s12, zero_s13, zero_s14;
	thp_pkg::result_t res_q;

	assign en = !vld_q[NST-1] || out_ch.ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	always_comb begin
		hfin = hum_s10 - thp_pkg::sra(hs_s10, 4);
		if (hfin[31]) begin
			hfin = '0;
		end
		if (hfin > thp_pkg::K_HUM_MAX) begin
			hfin = thp_pkg::K_HUM_MAX;
		end
		div_in.rem  = '0;
		div_in.num  = num_s10;
		div_in.den  = diva_s10;
		div_in.hi   = hi_s10;
		div_in.zero = zero_s10;
		div_in.temp = temp_s10;
		div_in.hum  = hfin[28:12];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s1 <= thp_pkg::sra(in_beat.fine + (in_beat.fine << 2) + thp_pkg::K_128, 8);
			pa_s1   <= thp_pkg::sra(in_beat.fine, 1) - thp_pkg::K_64000;
			q_s1    <= thp_pkg::sra(thp_pkg::sra(in_beat.fine, 1) - thp_pkg::K_64000, 2);
			hd_s1   <= in_beat.fine - thp_pkg::K_76800;
			adcp_s1 <= in_beat.raw_pressure;
			adch_s1 <= in_beat.raw_humidity;

			temp_s2 <= temp_s1;
			qq_s2   <= thp_pkg::mul32(q_s1, q_s1);
			mp5_s2  <= thp_pkg::mul32(pa_s1, coeff.p5);
			mp2_s2  <= thp_pkg::mul32(coeff.p2, pa_s1);
			h5d_s2  <= thp_pkg::mul32(coeff.h5, hd_s1);
			h6d_s2  <= thp_pkg::mul32(hd_s1, coeff.h6);
			h3d_s2  <= thp_pkg::mul32(hd_s1, coeff.h3);
			adcp_s2 <= adcp_s1;
			adch_s2 <= adch_s1;

			temp_s3 <= temp_s2;
			b1_s3   <= thp_pkg::mul32(thp_pkg::sra(qq_s2, 11), coeff.p6);
			c_s3    <= thp_pkg::mul32(coeff.p3, thp_pkg::sra(qq_s2, 13));
			mp5_s3  <= mp5_s2;
			mp2_s3  <= mp2_s2;
			ha_s3   <= thp_pkg::sra((32'(adch_s2) << 14) - (coeff.h4 << 20) - h5d_s2
				+ thp_pkg::K_16384, 15);
			hb_s3   <= thp_pkg::sra(h6d_s2, 10);
			hc_s3   <= thp_pkg::sra(h3d_s2, 11) + thp_pkg::K_32768;
			adcp_s3 <= adcp_s2;

			temp_s4 <= temp_s3;
			b_s4    <= thp_pkg::sra(b1_s3 + (mp5_s3 << 1), 2) + (coeff.p4 << 16);
			a1_s4   <= thp_pkg::sra(thp_pkg::sra(c_s3, 3) + thp_pkg::sra(mp2_s3, 1), 18);
			ha_s4   <= ha_s3;
			hbc_s4  <= thp_pkg::mul32(hb_s3, hc_s3);
			adcp_s4 <= adcp_s3;

			temp_s5 <= temp_s4;
			dv_s5   <= thp_pkg::mul32(thp_pkg::K_32768 + a1_s4, coeff.p1);
			pn_s5   <= (thp_pkg::K_1048576 - 32'(adcp_s4)) - thp_pkg::sra(b_s4, 12);
			hb2_s5  <= thp_pkg::sra(hbc_s4, 10) + thp_pkg::K_2097152;
			ha_s5   <= ha_s4;

			temp_s6 <= temp_s5;
			diva_s6 <= thp_pkg::sra(dv_s5, 15);
			pm_s6   <= thp_pkg::mul32(pn_s5, thp_pkg::K_3125);
			hb3_s6  <= thp_pkg::mul32(hb2_s5, coeff.h2);
			ha_s6   <= ha_s5;

			temp_s7 <= temp_s6;
			diva_s7 <= diva_s6;
			hi_s7   <= pm_s6[31];
			num_s7  <= pm_s6[31] ? pm_s6 : (pm_s6 << 1);
			ha_s7   <= ha_s6;
			hb4_s7  <= thp_pkg::sra(hb3_s6 + thp_pkg::K_8192, 14);

			temp_s8 <= temp_s7;
			diva_s8 <= diva_s7;
			num_s8  <= num_s7;
			hi_s8   <= hi_s7;
			zero_s8 <= diva_s7 == '0;
			hum_s8  <= thp_pkg::mul32(ha_s7, hb4_s7);

			temp_s9 <= temp_s8;
			diva_s9 <= diva_s8;
			num_s9  <= num_s8;
			hi_s9   <= hi_s8;
			zero_s9 <= zero_s8;
			hum_s9  <= hum_s8;
			hq_s9   <= thp_pkg::mul32(thp_pkg::sra(hum_s8, 15), thp_pkg::sra(hum_s8, 15));

			temp_s10 <= temp_s9;
			diva_s10 <= diva_s9;
			num_s10  <= num_s9;
			hi_s10   <= hi_s9;
			zero_s10 <= zero_s9;
			hum_s10  <= hum_s9;
			hs_s10   <= thp_pkg::mul32(thp_pkg::sra(hq_s9, 7), coeff.h1);
		end
	end

	for (genvar g = 0; g < DIVN; g++) begin : g_div
		div_t        cur;
		div_t        nxt;
		logic [32:0] trial;
		logic        ge;
		if (g == 0) begin : g_first
			assign cur = div_in;
		end else begin : g_rest
			assign cur = div_q[g-1];
		end
		always_comb begin
			nxt   = cur;
			trial = {cur.rem, cur.num[31]};
			ge    = trial >= {1'b0, cur.den};
			nxt.rem = ge ? 32'(trial - {1'b0, cur.den}) : trial[31:0];
			nxt.num = {cur.num[30:0], ge};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_q[g] <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s12 <= div_q[DIVN-1].temp;
			hum_s12  <= div_q[DIVN-1].hum;
			zero_s12 <= div_q[DIVN-1].zero;
			pres_s12 <= div_q[DIVN-1].hi ? (div_q[DIVN-1].num << 1) : div_q[DIVN-1].num;

			temp_s13 <= temp_s12;
			hum_s13  <= hum_s12;
			zero_s13 <= zero_s12;
			pres_s13 <= pres_s12;
			ss_s13   <= thp_pkg::mul32(pres_s12 >> 3, pres_s12 >> 3);
			pb_s13   <= thp_pkg::mul32(pres_s12 >> 2, coeff.p8);

			temp_s14 <= temp_s13;
			hum_s14  <= hum_s13;
			zero_s14 <= zero_s13;
			pres_s14 <= pres_s13;
			pa2_s14  <= thp_pkg::mul32(coeff.p9, ss_s13 >> 13);
			pb_s14   <= thp_pkg::sra(pb_s13, 13);

			res_q.temperature_centi <= $signed(temp_s14);
			res_q.humidity_q10      <= hum_s14;
			res_q.pressure_pa       <= zero_s14 ? '0 : pres_s14 + thp_pkg::sra(
				thp_pkg::sra(pa2_s14, 12) + pb_s14 + coeff.p7, 4);
		end
	end

	assign out_ch.valid = vld_q[NST-1];
	assign out_ch.data  = res_q;
endmodule
`default_nettype wire

/* src/thp_sensor_compensation.sv */
// Top level of the temperature, pressure and humidity compensation block
//
// Raw readings enter on in_ch (valid/ready beats of raw temperature, pressure
// and humidity); compensated results leave on out_ch, one result per reading,
// in order. Calibration coefficients are written through cfg_we, cfg_index and
// cfg_data, one packed register per write; the user must write them only while
// the block is idle (the block does not enforce this). A front pipeline of 4
// stages derives the fine temperature and pushes it into a short queue; a back
// pipeline of 46 stages (10 arithmetic stages, a 32-stage restoring divider at
// one quotient bit per stage, 4 finishing stages) produces the result. While
// out_ch.ready is high, throughput is one reading per cycle (pipelined divider).
// Reset clears the coefficients, all valid flags and the queue pointers.
// While out_ch.valid is high and out_ch.ready low the back pipeline holds; the
// queue absorbs up to QUEUE_DEPTH beats from the front before in_ch.ready drops.
`default_nettype none
module thp_sensor_compensation #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	thp_in_if.sink           in_ch,
	thp_out_if.source        out_ch,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	logic [47:0] temp_q;
	logic [63:0] plo_q, phi_q, hum_q;
	logic [15:0] p9_q;
	thp_pkg::coeff_t     coeff;
	logic                push_valid, push_ready, pop_valid, pop_ready;
	thp_pkg::fine_beat_t push_beat, pop_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0;
			plo_q  <= '0;
			phi_q  <= '0;
			p9_q   <= '0;
			hum_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				thp_pkg::CFG_TEMP:     temp_q <= cfg_data[47:0];
				thp_pkg::CFG_PRESS_LO: plo_q  <= cfg_data;
				thp_pkg::CFG_PRESS_HI: phi_q  <= cfg_data;
				thp_pkg::CFG_PRESS_P9: p9_q   <= cfg_data[15:0];
				thp_pkg::CFG_HUM:      hum_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		coeff.t1 = 32'(temp_q[15:0]);
		coeff.t2 = 32'($signed(temp_q[31:16]));
		coeff.t3 = 32'($signed(temp_q[47:32]));
		coeff.p1 = 32'(plo_q[15:0]);
		coeff.p2 = 32'($signed(plo_q[31:16]));
		coeff.p3 = 32'($signed(plo_q[47:32]));
		coeff.p4 = 32'($signed(plo_q[63:48]));
		coeff.p5 = 32'($signed(phi_q[15:0]));
		coeff.p6 = 32'($signed(phi_q[31:16]));
		coeff.p7 = 32'($signed(phi_q[47:32]));
		coeff.p8 = 32'($signed(phi_q[63:48]));
		coeff.p9 = 32'($signed(p9_q));
		coeff.h1 = 32'(hum_q[7:0]);
		coeff.h2 = 32'($signed(hum_q[23:8]));
		coeff.h3 = 32'(hum_q[31:24]);
		coeff.h4 = 32'($signed(hum_q[43:32]));
		coeff.h5 = 32'($signed(hum_q[55:44]));
		coeff.h6 = 32'($signed(hum_q[63:56]));
	end

	thp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.coeff      (coeff),
		.push_valid (push_valid),
		.push_beat  (push_beat),
		.push_ready (push_ready)
	);

	thp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_beat  (push_beat),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_beat   (pop_beat),
		.pop_ready  (pop_ready)
	);

	thp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pop_valid),
		.in_beat  (pop_beat),
		.in_ready (pop_ready),
		.coeff    (coeff),
		.out_ch   (out_ch)
	);
endmodule
`default_nettype wire
